[hdl/time_tagged_command_table_top_macros.svh]
// Assertion macros used by the command table engine.
`ifndef TIME_TAGGED_COMMAND_TABLE_TOP_MACROS_SVH
`define TIME_TAGGED_COMMAND_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define TTCT_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttct assertion failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define TTCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttct assertion failed");

`endif

[hdl/ttct_pkg.sv]
// Types, codes and sizes shared by the time-tagged command table.
package ttct_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int TABLE_DEPTH = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = 5;
  localparam int SLOT_W      = 4;
  localparam int CFG_W       = 5;
  localparam int HANDLE_W    = 16;
  localparam int IDENT_W     = 16;
  localparam int TIME_W      = 32;
  localparam int CMD_W       = 3;
  localparam int EV_W        = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_LOAD         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ABORT_HANDLE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ABORT_IDENT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACTIVATE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH        = 3'd4;

  // Result event codes
  localparam logic [EV_W-1:0] EV_LOADED      = 3'd0;
  localparam logic [EV_W-1:0] EV_REJ_INVALID = 3'd1;
  localparam logic [EV_W-1:0] EV_REJ_FULL    = 3'd2;
  localparam logic [EV_W-1:0] EV_ABORTED     = 3'd3;
  localparam logic [EV_W-1:0] EV_DISPATCHED  = 3'd4;
  localparam logic [EV_W-1:0] EV_DONE        = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_REJECT,
    OP_ABORT_HANDLE,
    OP_ABORT_IDENT,
    OP_ACTIVATE,
    OP_FLUSH,
    OP_NONE
  } op_kind_t;

  // Classified command as it travels from front to back; stamp is the load
  // tag or the activation time.
  typedef struct packed {
    op_kind_t              kind;
    logic [HANDLE_W-1:0]   handle;
    logic [IDENT_W-1:0]    ident;
    logic [TIME_W-1:0]     stamp;
  } op_t;

endpackage

[hdl/ttct_if.sv]
// Valid/ready channel interfaces for commands and results.
interface ttct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] cmd_handle;
  logic [15:0] cmd_ident;
  logic [31:0] time_tag;
  logic        is_valid;
  logic [31:0] now_time;

  modport source (output valid, command, cmd_handle, cmd_ident, time_tag, is_valid,
                  now_time, input ready);
  modport sink (input valid, command, cmd_handle, cmd_ident, time_tag, is_valid,
                now_time, output ready);
endinterface

interface ttct_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] out_handle;
  logic [15:0] out_ident;
  logic [3:0]  slot_index;
  logic [4:0]  pending_now;
  logic        last_result;

  modport source (output valid, event_res, out_handle, out_ident, slot_index,
                  pending_now, last_result, input ready);
  modport sink (input valid, event_res, out_handle, out_ident, slot_index,
                pending_now, last_result, output ready);
endinterface

[hdl/ttct_front.sv]
// Command intake: accepts transactions and classifies them for the queue.
module ttct_front
  import ttct_pkg::*;
(
  ttct_in_if.sink cmd_in,
  input  logic    q_full,
  output logic    q_push,
  output op_t     q_data
);

  assign cmd_in.ready = !q_full;
  assign q_push       = cmd_in.valid && !q_full;

  always_comb begin
    q_data.handle = cmd_in.cmd_handle;
    q_data.ident  = cmd_in.cmd_ident;
    q_data.stamp  = cmd_in.time_tag;
    case (cmd_in.command)
      CMD_LOAD: begin
        q_data.kind = cmd_in.is_valid ? OP_LOAD : OP_REJECT;
      end
      CMD_ABORT_HANDLE: begin
        q_data.kind = OP_ABORT_HANDLE;
      end
      CMD_ABORT_IDENT: begin
        q_data.kind = OP_ABORT_IDENT;
      end
      CMD_ACTIVATE: begin
        q_data.kind  = OP_ACTIVATE;
        q_data.stamp = cmd_in.now_time;
      end
      CMD_FLUSH: begin
        q_data.kind = OP_FLUSH;
      end
      default: begin
        q_data.kind = OP_NONE;
      end
    endcase
  end

endmodule

[hdl/ttct_queue.sv]
// Short FIFO of classified commands between intake and table engine.
module ttct_queue
  import ttct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  output logic valid,
  output op_t  head,
  input  logic pop
);

  op_t                entry [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entry[rd_ptr];

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && valid) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !(pop && valid)) begin
        count <= count + 1'b1;
      end else if (!push && pop && valid) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/ttct_back.sv]
// Engine: holds the slots, scans one per unstalled cycle, registers results.
`include "time_tagged_command_table_top_macros.svh"

module ttct_back
  import ttct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic         q_valid,
  input  op_t          q_data,
  output logic         q_pop,
  ttct_out_if.source   res_out
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state, state_next;
  op_t                 cmd;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    last_idx;
  logic [TABLE_DEPTH-1:0] busy;
  logic [COUNT_W-1:0]  pending, pend_next;

  logic [HANDLE_W-1:0] slot_handle [TABLE_DEPTH];
  logic [IDENT_W-1:0]  slot_ident  [TABLE_DEPTH];
  logic [TIME_W-1:0]   slot_time   [TABLE_DEPTH];

  logic [HANDLE_W-1:0] rd_handle;
  logic [IDENT_W-1:0]  rd_ident;
  logic [TIME_W-1:0]   rd_time;
  logic                match, hit;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  logic                out_vld, out_free;
  logic                emit, set_slot, clr_slot;
  logic [EV_W-1:0]     e_ev;
  logic [HANDLE_W-1:0] e_handle;
  logic [IDENT_W-1:0]  e_ident;
  logic [SLOT_W-1:0]   e_slot;
  logic                e_last;

  logic [EV_W-1:0]     out_ev;
  logic [HANDLE_W-1:0] out_handle;
  logic [IDENT_W-1:0]  out_ident;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_pend;
  logic                out_last;

  assign out_free = !out_vld || res_out.ready;

  assign rd_handle = slot_handle[idx];
  assign rd_ident  = slot_ident[idx];
  assign rd_time   = slot_time[idx];

  always_comb begin
    case (cmd.kind)
      OP_ABORT_HANDLE: match = (rd_handle == cmd.handle);
      OP_ABORT_IDENT:  match = (rd_ident == cmd.ident);
      OP_ACTIVATE:     match = (rd_time <= cmd.stamp);
      OP_FLUSH:        match = 1'b1;
      default:         match = 1'b0;
    endcase
  end
  assign hit = busy[idx] && match;

  // Lowest free slot inside the active size
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!busy[i] && (IDX_W'(i) <= last_idx)) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_pop      = 1'b0;
    emit       = 1'b0;
    set_slot   = 1'b0;
    clr_slot   = 1'b0;
    e_ev       = EV_DONE;
    e_handle   = '0;
    e_ident    = '0;
    e_slot     = '0;
    e_last     = 1'b0;
    pend_next  = pending;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          idx_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (cmd.kind)
          OP_REJECT: begin
            if (out_free) begin
              emit       = 1'b1;
              e_ev       = EV_REJ_INVALID;
              e_handle   = cmd.handle;
              e_ident    = cmd.ident;
              state_next = ST_DONE;
            end
          end
          OP_LOAD: begin
            if (out_free) begin
              emit     = 1'b1;
              e_handle = cmd.handle;
              e_ident  = cmd.ident;
              if (free_found) begin
                e_ev      = EV_LOADED;
                e_slot    = SLOT_W'(free_idx);
                set_slot  = 1'b1;
                pend_next = pending + 1'b1;
              end else begin
                e_ev = EV_REJ_FULL;
              end
              state_next = ST_DONE;
            end
          end
          OP_ABORT_HANDLE, OP_ABORT_IDENT, OP_ACTIVATE, OP_FLUSH: begin
            // hold on a match until the output register can take it
            if (!hit || out_free) begin
              if (hit) begin
                emit     = 1'b1;
                clr_slot = 1'b1;
                e_ev     = (cmd.kind == OP_ACTIVATE) ? EV_DISPATCHED : EV_ABORTED;
                e_handle = rd_handle;
                e_ident  = rd_ident;
                e_slot   = SLOT_W'(idx);
                if (pending != '0) begin
                  pend_next = pending - 1'b1;
                end
              end
              if ((hit && cmd.kind == OP_ABORT_HANDLE) || idx == last_idx) begin
                state_next = ST_DONE;
              end else begin
                idx_next = idx + 1'b1;
              end
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      busy     <= '0;
      pending  <= '0;
      last_idx <= IDX_W'(TABLE_DEPTH - 1);
      out_vld  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_wr_en) begin
        // clamp the active size to 1..TABLE_DEPTH and empty the table
        if (cfg_wr_data == '0) begin
          last_idx <= '0;
        end else if (cfg_wr_data > CFG_W'(TABLE_DEPTH)) begin
          last_idx <= IDX_W'(TABLE_DEPTH - 1);
        end else begin
          last_idx <= IDX_W'(cfg_wr_data - 1'b1);
        end
        busy    <= '0;
        pending <= '0;
      end else begin
        if (set_slot) begin
          busy[free_idx] <= 1'b1;
        end
        if (clr_slot) begin
          busy[idx] <= 1'b0;
        end
        pending <= pend_next;
      end
      if (emit) begin
        out_vld <= 1'b1;
      end else if (res_out.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (set_slot) begin
      slot_handle[free_idx] <= cmd.handle;
      slot_ident[free_idx]  <= cmd.ident;
      slot_time[free_idx]   <= cmd.stamp;
    end
    if (emit) begin
      out_ev     <= e_ev;
      out_handle <= e_handle;
      out_ident  <= e_ident;
      out_slot   <= e_slot;
      out_pend   <= pend_next;
      out_last   <= e_last;
    end
  end

  assign res_out.valid       = out_vld;
  assign res_out.event_res   = out_ev;
  assign res_out.out_handle  = out_handle;
  assign res_out.out_ident   = out_ident;
  assign res_out.slot_index  = out_slot;
  assign res_out.pending_now = out_pend;
  assign res_out.last_result = out_last;

  `TTCT_ASSERT(a_pending_tracks_busy, 1'b1, pending == COUNT_W'($countones(busy)))
  `TTCT_ASSERT(a_scan_in_range, state == ST_SCAN, idx <= last_idx)
  `TTCT_ASSERT(a_free_only_busy, emit && (e_ev == EV_ABORTED || e_ev == EV_DISPATCHED), busy[idx])
  `TTCT_ASSERT_NEXT(a_done_emits_last, (state == ST_DONE) && out_free, out_vld && out_last)

endmodule

[hdl/time_tagged_command_table_top.sv]
// Time-tagged command table: holds pending commands, loads, aborts and dispatches them.
//
// Channels: cmd_in takes one command per transaction (load, abort by handle,
// abort by id, activate at now_time, flush); res_out gives the events that a
// command causes, in slot order, then one done result with last_result set.
// cfg_wr_en/cfg_wr_data set the active table size (1..16) and empty the table;
// write it only while no command is in flight.
// From an empty queue, a command passes the queue entry and the engine's command
// register before its first result is registered. Load, rejects and unknown codes
// pass through the engine's idle, scan and done states; abort, activate and flush
// scan one slot per cycle while no match waits on the result register, over the
// active size, stopping early on a handle match. The slot scan bounds the command
// rate; a 2-entry queue lets intake accept further commands while the engine works.
// Reset empties the table and sets the size to 16; no clearing pass is run.
// When the receiver stalls, the result register holds and the scan waits on
// its next event; intake stops once the queue is full.
module time_tagged_command_table_top
  import ttct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  ttct_in_if.sink          cmd_in,
  ttct_out_if.source       res_out
);

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  op_t  q_in;
  op_t  q_head;

  ttct_front u_front (
    .cmd_in (cmd_in),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  ttct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  ttct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .res_out     (res_out)
  );

endmodule

[bench/ttct_checker.sv]
`timescale 1ns / 1ps
// Watches the command table's channels, predicts every result and compares.
module ttct_checker
  import ttct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  ttct_in_if               cmd_in,
  ttct_out_if              res_out,
  output int               mismatches,
  output int               awaiting,
  output int               checked,
  output int               dispatched,
  output int               rejected_full
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [EV_W-1:0]     ev;
    logic [HANDLE_W-1:0] handle;
    logic [IDENT_W-1:0]  ident;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  pending;
    logic                last;
  } table_event_t;

  table_event_t        owed_events[$];
  logic [CFG_W-1:0]    size_reg;
  logic                slot_live[TABLE_DEPTH];
  logic [HANDLE_W-1:0] slot_hdl[TABLE_DEPTH];
  logic [IDENT_W-1:0]  slot_id[TABLE_DEPTH];
  logic [TIME_W-1:0]   slot_tag[TABLE_DEPTH];
  logic [COUNT_W-1:0]  live_count;

  function automatic void empty_table();
    for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
    live_count = '0;
  endfunction

  function automatic void post_event(logic [EV_W-1:0] ev, logic [HANDLE_W-1:0] h,
                                     logic [IDENT_W-1:0] id, int slot, logic last);
    table_event_t e;
    e.ev      = ev;
    e.handle  = h;
    e.ident   = id;
    e.slot    = slot[SLOT_W-1:0];
    e.pending = live_count;
    e.last    = last;
    owed_events.push_back(e);
  endfunction

  function automatic void retire_slot(int i, logic [EV_W-1:0] ev);
    slot_live[i] = 1'b0;
    if (live_count > 0) live_count = live_count - 1'b1;
    post_event(ev, slot_hdl[i], slot_id[i], i, 1'b0);
  endfunction

  // Work out every event one command causes, ending with its done event.
  function automatic void run_command(logic [CMD_W-1:0] op, logic [HANDLE_W-1:0] h,
                                      logic [IDENT_W-1:0] id, logic [TIME_W-1:0] tag,
                                      logic ok, logic [TIME_W-1:0] now);
    int sz;
    int free_at;
    sz = size_reg;
    if (sz < 1) sz = 1;
    if (sz > TABLE_DEPTH) sz = TABLE_DEPTH;
    case (op)
      CMD_LOAD: begin
        if (!ok) begin
          post_event(EV_REJ_INVALID, h, id, 0, 1'b0);
        end else begin
          free_at = -1;
          for (int i = 0; i < sz; i++)
            if (!slot_live[i] && free_at < 0) free_at = i;
          if (free_at < 0) begin
            post_event(EV_REJ_FULL, h, id, 0, 1'b0);
          end else begin
            slot_live[free_at] = 1'b1;
            slot_hdl[free_at]  = h;
            slot_id[free_at]   = id;
            slot_tag[free_at]  = tag;
            live_count = live_count + 1'b1;
            post_event(EV_LOADED, h, id, free_at, 1'b0);
          end
        end
      end
      CMD_ABORT_HANDLE: begin
        for (int i = 0; i < sz; i++) begin
          if (slot_live[i] && slot_hdl[i] == h) begin
            retire_slot(i, EV_ABORTED);
            break;
          end
        end
      end
      CMD_ABORT_IDENT: begin
        for (int i = 0; i < sz; i++)
          if (slot_live[i] && slot_id[i] == id) retire_slot(i, EV_ABORTED);
      end
      CMD_ACTIVATE: begin
        for (int i = 0; i < sz; i++)
          if (slot_live[i] && slot_tag[i] <= now) retire_slot(i, EV_DISPATCHED);
      end
      CMD_FLUSH: begin
        for (int i = 0; i < sz; i++)
          if (slot_live[i]) retire_slot(i, EV_ABORTED);
      end
      default: ;
    endcase
    post_event(EV_DONE, '0, '0, 0, 1'b1);
  endfunction

  always @(posedge clk) begin : watch
    table_event_t got;
    table_event_t want;
    logic         bad;
    if (rst) begin
      size_reg = CFG_W'(MAX_SLOTS);
      empty_table();
      owed_events.delete();
      mismatches    = 0;
      checked       = 0;
      dispatched    = 0;
      rejected_full = 0;
    end else begin
      // Compare results before queueing new ones, so a stray result never
      // matches an event of the command accepted at the same edge.
      if (res_out.valid && res_out.ready) begin
        got = '{ev: res_out.event_res, handle: res_out.out_handle,
                ident: res_out.out_ident, slot: res_out.slot_index,
                pending: res_out.pending_now, last: res_out.last_result};
        checked++;
        if (got.ev == EV_DISPATCHED) dispatched++;
        if (got.ev == EV_REJ_FULL) rejected_full++;
        if (owed_events.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result ev=%0d h=%h id=%h slot=%0d pend=%0d last=%0b",
                     $time, got.ev, got.handle, got.ident, got.slot, got.pending, got.last);
        end else begin
          want = owed_events.pop_front();
          bad = (got.ev !== want.ev) || (got.handle !== want.handle) ||
                (got.ident !== want.ident) || (got.slot !== want.slot) ||
                (got.pending !== want.pending) || (got.last !== want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: result mismatch", $time);
              $display("  expected ev=%0d h=%h id=%h slot=%0d pend=%0d last=%0b",
                       want.ev, want.handle, want.ident, want.slot, want.pending, want.last);
              $display("  actual   ev=%0d h=%h id=%h slot=%0d pend=%0d last=%0b",
                       got.ev, got.handle, got.ident, got.slot, got.pending, got.last);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        size_reg = cfg_wr_data;
        empty_table();
      end
      if (cmd_in.valid && cmd_in.ready)
        run_command(cmd_in.command, cmd_in.cmd_handle, cmd_in.cmd_ident, cmd_in.time_tag,
                    cmd_in.is_valid, cmd_in.now_time);
    end
    awaiting <= owed_events.size();
  end

endmodule

[bench/tb_time_tagged_command_table_top.sv]
`timescale 1ns / 1ps
// Testbench top for the command table: clock, reset, commands, size writes, verdict.
module tb_time_tagged_command_table_top;
  import ttct_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 44;
  localparam int PHASE_COUNT   = 9;
  localparam logic [CMD_W-1:0] CMD_CODE_MAX = '1;

  typedef enum {PACE_FREE, PACE_RANDOM, PACE_LONG} pace_t;

  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic [HANDLE_W-1:0] handle;
    logic [IDENT_W-1:0]  ident;
    logic [TIME_W-1:0]   tag;
    logic                ok;
    logic [TIME_W-1:0]   now;
  } table_cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  ttct_in_if  cmd_if ();
  ttct_out_if res_if ();

  int  mismatches, awaiting, checked, dispatched, rejected_full;
  int  sent, burst_left, idle_cycles, size_writes;
  bit  bursty;
  pace_t pace = PACE_FREE;
  logic [TIME_W-1:0]   obc_clock;
  logic [HANDLE_W-1:0] handle_pool[8];
  logic [IDENT_W-1:0]  ident_pool[6];

  time_tagged_command_table_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_in      (cmd_if),
    .res_out     (res_if)
  );

  ttct_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd_in        (cmd_if),
    .res_out       (res_if),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .checked       (checked),
    .dispatched    (dispatched),
    .rejected_full (rejected_full)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Receiver pacing: runs of ready and stall whose shape depends on the pace.
  initial begin : rx_pace
    int   run_left;
    logic rx_open;
    run_left = 0;
    rx_open  = 1'b1;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        case (pace)
          PACE_FREE: begin
            rx_open  = 1'b1;
            run_left = $urandom_range(8, 40);
          end
          PACE_RANDOM: begin
            rx_open  = ($urandom_range(0, 3) != 0);
            run_left = 1;
          end
          default: begin
            rx_open  = !rx_open;
            run_left = rx_open ? $urandom_range(1, 6) : $urandom_range(3, 15);
          end
        endcase
      end
      run_left--;
      res_if.ready <= rx_open;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results owed",
                 idle_cycles, awaiting);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic table_cmd_t mk(logic [CMD_W-1:0] op, logic [HANDLE_W-1:0] h,
                                    logic [IDENT_W-1:0] id, logic [TIME_W-1:0] tag,
                                    logic ok, logic [TIME_W-1:0] now);
    table_cmd_t c;
    c = '{op: op, handle: h, ident: id, tag: tag, ok: ok, now: now};
    return c;
  endfunction

  // Mostly commands on a small set of handles and ids near the running clock,
  // so that aborts hit and activations dispatch; the rest is raw noise.
  function automatic table_cmd_t pick_command();
    table_cmd_t c;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      c.op = CMD_LOAD;
    else if (roll < 57) c.op = CMD_ABORT_HANDLE;
    else if (roll < 67) c.op = CMD_ABORT_IDENT;
    else if (roll < 90) c.op = CMD_ACTIVATE;
    else if (roll < 94) c.op = CMD_FLUSH;
    else                c.op = CMD_W'($urandom_range(CMD_FLUSH + 1, CMD_CODE_MAX));
    c.handle = ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom)
                                           : handle_pool[$urandom_range(0, 7)];
    c.ident  = ($urandom_range(0, 9) == 0) ? IDENT_W'($urandom)
                                           : ident_pool[$urandom_range(0, 5)];
    c.ok = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0:       c.tag = '0;
      1:       c.tag = $urandom;
      2:       c.tag = '1;
      default: c.tag = obc_clock + $urandom_range(0, 300);
    endcase
    if (c.op == CMD_ACTIVATE) obc_clock = obc_clock + $urandom_range(0, 120);
    case ($urandom_range(0, 9))
      0:       c.now = $urandom;
      1:       c.now = '1;
      default: c.now = obc_clock;
    endcase
    return c;
  endfunction

  // Call at a falling edge; returns at a falling edge after acceptance.
  task automatic issue(table_cmd_t c);
    cmd_if.command    <= c.op;
    cmd_if.cmd_handle <= c.handle;
    cmd_if.cmd_ident  <= c.ident;
    cmd_if.time_tag   <= c.tag;
    cmd_if.is_valid   <= c.ok;
    cmd_if.now_time   <= c.now;
    cmd_if.valid      <= 1'b1;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      if (bursty) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  endtask

  // Wait until every owed result has come, then let the engine go quiet.
  task automatic drain();
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_table_size(logic [CFG_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    size_writes++;
    repeat (2) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] sizes[PHASE_COUNT];
    sizes = '{5'd1, 5'd0, 5'd5, 5'd31, 5'd16, 5'd17, 5'd2, 5'd9, 5'd16};
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_LOAD;
    cmd_if.cmd_handle = '0;
    cmd_if.cmd_ident  = '0;
    cmd_if.time_tag   = '0;
    cmd_if.is_valid   = 1'b0;
    cmd_if.now_time   = '0;
    sent        = 0;
    size_writes = 0;
    burst_left  = 8;
    bursty      = 1'b0;
    obc_clock   = '0;
    foreach (handle_pool[i]) handle_pool[i] = HANDLE_W'($urandom);
    foreach (ident_pool[i]) ident_pool[i] = IDENT_W'($urandom);
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    ident_pool[0]  = '0;
    ident_pool[1]  = '1;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed pass at the reset size of sixteen slots.
    pace = PACE_RANDOM;
    issue(mk(CMD_ACTIVATE, '0, '0, '0, 1'b0, '0));
    issue(mk(CMD_ABORT_HANDLE, '0, '0, '0, 1'b1, '0));
    issue(mk(CMD_FLUSH, '0, '0, '0, 1'b1, '0));
    issue(mk(CMD_LOAD, '1, '1, '1, 1'b0, '0));
    issue(mk(CMD_LOAD, '0, '0, '0, 1'b1, '0));
    issue(mk(CMD_LOAD, '1, '1, '1, 1'b1, '0));
    issue(mk(CMD_LOAD, 16'h1234, '0, 32'd10, 1'b1, '0));
    issue(mk(CMD_LOAD, 16'h1234, 16'h55aa, 32'd20, 1'b1, '0));
    for (int code = CMD_FLUSH + 1; code <= CMD_CODE_MAX; code++)
      issue(mk(CMD_W'(code), HANDLE_W'($urandom), IDENT_W'($urandom), $urandom, 1'b1,
               $urandom));
    // Duplicate handle: only the lowest match goes.
    issue(mk(CMD_ABORT_HANDLE, 16'h1234, '0, '0, 1'b1, '0));
    issue(mk(CMD_ABORT_HANDLE, 16'h9999, '0, '0, 1'b1, '0));
    // Identifier zero, matched across a busy slot in between.
    issue(mk(CMD_LOAD, 16'h0002, '0, 32'd30, 1'b1, '0));
    issue(mk(CMD_ABORT_IDENT, '0, '0, '0, 1'b1, '0));
    // Tags are due at or before now, including the all-ones tag.
    issue(mk(CMD_ACTIVATE, '0, '0, '0, 1'b1, 32'd19));
    issue(mk(CMD_ACTIVATE, '0, '0, '0, 1'b1, 32'd20));
    issue(mk(CMD_ACTIVATE, '0, '0, '0, 1'b1, 32'hffff_fffe));
    issue(mk(CMD_ACTIVATE, '0, '0, '0, 1'b1, '1));
    issue(mk(CMD_LOAD, 16'h0003, 16'h0003, '0, 1'b1, '0));
    issue(mk(CMD_LOAD, 16'h0004, 16'h0004, 32'd1, 1'b1, '0));
    issue(mk(CMD_LOAD, 16'h0005, 16'h0005, 32'h7fff_ffff, 1'b1, '0));
    issue(mk(CMD_FLUSH, '0, '0, '0, 1'b1, '0));
    cmd_if.valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_table_size(sizes[p]);
      bursty    = p[0];
      pace      = pace_t'(p % 3);
      obc_clock = (p == 3) ? 32'hffff_f000 : $urandom_range(0, 5000);
      repeat (PHASE_ITEMS) issue(pick_command());
      cmd_if.valid <= 1'b0;
      drain();
    end

    $display("Ran %0d commands over %0d table size writes plus the reset size.",
             sent, size_writes);
    $display("Compared %0d results: %0d dispatches, %0d full-table rejections, %0d mismatches.",
             checked, dispatched, rejected_full, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ttct_pkg.sv
hdl/ttct_if.sv
hdl/ttct_front.sv
hdl/ttct_queue.sv
hdl/ttct_back.sv
hdl/time_tagged_command_table_top.sv
bench/ttct_checker.sv
bench/tb_time_tagged_command_table_top.sv
